// File: sv/svm_pkg.sv
// Package for the stack machine core: beat types, opcodes, status and mode codes.
// Used by stack_vm_instruction_step; depends on nothing.
package svm_pkg;

    localparam int MEM_WORDS_DEF = 4096;

    typedef struct packed {
        logic [1:0]         mode;
        logic [14:0]        address;
        logic signed [63:0] write_value;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]         status;
        logic [14:0]        program_counter;
        logic signed [63:0] accumulator;
        logic [15:0]        stack_pointer;
        logic [15:0]        frame_pointer;
        logic signed [63:0] read_value;
        logic [31:0]        instruction_count;
    } t_out_beat;

    // item modes
    localparam logic [1:0] MD_WRITE = 2'd0;
    localparam logic [1:0] MD_READ  = 2'd1;
    localparam logic [1:0] MD_START = 2'd2;
    localparam logic [1:0] MD_EXEC  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ENTRY = 2'd0;
    localparam logic [1:0] CFG_ARGC  = 2'd1;
    localparam logic [1:0] CFG_ARGV  = 2'd2;

    // run status
    localparam logic [2:0] ST_RUN  = 3'd0;
    localparam logic [2:0] ST_EXIT = 3'd1;
    localparam logic [2:0] ST_BAD  = 3'd2;
    localparam logic [2:0] ST_HOST = 3'd3;
    localparam logic [2:0] ST_DIV0 = 3'd4;

    // opcodes
    localparam logic [5:0] OP_IMM  = 6'd0;
    localparam logic [5:0] OP_LEA  = 6'd1;
    localparam logic [5:0] OP_JMP  = 6'd2;
    localparam logic [5:0] OP_JZ   = 6'd3;
    localparam logic [5:0] OP_JNZ  = 6'd4;
    localparam logic [5:0] OP_CALL = 6'd5;
    localparam logic [5:0] OP_NVAR = 6'd6;
    localparam logic [5:0] OP_DARG = 6'd7;
    localparam logic [5:0] OP_RET  = 6'd8;
    localparam logic [5:0] OP_LI   = 6'd9;
    localparam logic [5:0] OP_LC   = 6'd10;
    localparam logic [5:0] OP_SI   = 6'd11;
    localparam logic [5:0] OP_SC   = 6'd12;
    localparam logic [5:0] OP_PUSH = 6'd13;
    localparam logic [5:0] OP_OR   = 6'd14;
    localparam logic [5:0] OP_XOR  = 6'd15;
    localparam logic [5:0] OP_AND  = 6'd16;
    localparam logic [5:0] OP_EQ   = 6'd17;
    localparam logic [5:0] OP_NE   = 6'd18;
    localparam logic [5:0] OP_LT   = 6'd19;
    localparam logic [5:0] OP_GT   = 6'd20;
    localparam logic [5:0] OP_LE   = 6'd21;
    localparam logic [5:0] OP_GE   = 6'd22;
    localparam logic [5:0] OP_SHL  = 6'd23;
    localparam logic [5:0] OP_SHR  = 6'd24;
    localparam logic [5:0] OP_ADD  = 6'd25;
    localparam logic [5:0] OP_SUB  = 6'd26;
    localparam logic [5:0] OP_MUL  = 6'd27;
    localparam logic [5:0] OP_DIV  = 6'd28;
    localparam logic [5:0] OP_MOD  = 6'd29;
    localparam logic [5:0] OP_HOST_LO = 6'd30;
    localparam logic [5:0] OP_HOST_HI = 6'd37;
    localparam logic [5:0] OP_EXIT = 6'd38;
    localparam logic [5:0] OP_BAD  = 6'd63;  // any word above the opcode range

endpackage

// File: sv/stack_vm_instruction_step.sv
// Stack machine core: sequencer, register file, word memory, multiplier and divider.
// Depends on svm_pkg.
//
// One beat in gives one beat out. A start writes five stack pushes through the single memory
// port. An instruction runs fetch, operand access, commit and hand-off; PUSH and one that halts
// at its opcode (unknown opcode, host call, divide by zero) commit at the opcode, a halted
// machine only hands off, RET and SC take a second memory step, MUL forms three 32x32 partial
// products on one multiplier, and DIV and MOD run a restoring divider, one quotient bit a
// cycle. Memory is one synchronous RAM with one write and one read port and a registered read;
// MEM_WORDS must be a power of two. Every access is sequenced so that a read never meets a
// write in the same cycle. Results sit in an output register, so the next beat can be taken
// while the previous result waits downstream.
module stack_vm_instruction_step
    import svm_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_beat,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_beat,
    input  logic      i_out_stall
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [15:0] SP_TOP = 16'((MEM_WORDS * 8) % 65536);
    localparam logic [15:0] TRAMP  = SP_TOP - 16'd16;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_OP    = 4'd3;
    localparam logic [3:0] S_EX1   = 4'd4;
    localparam logic [3:0] S_EX2   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_MULF  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_DIVF  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    function automatic logic [AW-1:0] f_idx(input logic [63:0] a);
        return a[AW+2:3];
    endfunction

    function automatic logic [63:0] f_sext8(input logic [7:0] b);
        return {{56{b[7]}}, b};
    endfunction

    function automatic logic [63:0] f_abs(input logic [63:0] a);
        return a[63] ? (~a + 64'd1) : a;
    endfunction

    // configuration
    logic [14:0] r_entry;
    logic [15:0] r_argc;
    logic [14:0] r_argv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
            r_argc  <= '0;
            r_argv  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENTRY: r_entry <= i_cfg_data[14:0];
                CFG_ARGC:  r_argc  <= i_cfg_data;
                CFG_ARGV:  r_argv  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // machine state and sequencer
    logic [3:0]  r_state, n_state;
    logic [14:0] r_pc, n_pc;
    logic [15:0] r_sp, n_sp;
    logic [15:0] r_bp, n_bp;
    logic [63:0] r_acc, n_acc;
    logic [31:0] r_count, n_count;
    logic [2:0]  r_status, n_status;
    logic [63:0] r_rv, n_rv;
    logic [5:0]  r_opc, n_opc;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_out_valid, n_out_valid;
    t_out_beat   r_out, n_out;

    // scratch for SC, MUL, DIV
    logic [AW-1:0] r_widx, n_widx;
    logic [2:0]    r_bsel, n_bsel;
    logic [63:0]   r_ma, n_ma;
    logic [63:0]   r_p0, n_p0;
    logic [31:0]   r_p1, n_p1;
    logic [63:0]   r_dq, n_dq;
    logic [63:0]   r_dr, n_dr;
    logic [63:0]   r_dd, n_dd;
    logic          r_dnq, n_dnq;
    logic          r_dnr, n_dnr;

    // memory port
    logic [63:0]   mem [MEM_WORDS];
    logic [63:0]   r_q;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_widx, mem_ridx;
    logic [63:0]   mem_wdata;

    logic        in_acc;
    logic [15:0] sp_m8, sp_p8;
    logic [14:0] pc_p8;
    logic [5:0]  opc;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;
    logic [64:0] div_t;
    logic [63:0] sc_word;
    logic [63:0] lc_word;
    logic [63:0] q_res, r_res;

    assign in_acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign sp_m8 = r_sp - 16'd8;
    assign sp_p8 = r_sp + 16'd8;
    assign pc_p8 = r_pc + 15'd8;
    assign opc = (|r_q[63:6]) ? OP_BAD : r_q[5:0];

    // one shared 32x32 multiplier: lo*lo, lo*hi, hi*lo
    assign mul_x = (r_cnt[1:0] == 2'd2) ? r_ma[63:32] : r_ma[31:0];
    assign mul_y = (r_cnt[1:0] == 2'd1) ? r_acc[63:32] : r_acc[31:0];
    assign mul_p = mul_x * mul_y;

    // restoring divider trial subtract
    assign div_t = {r_dr, r_dq[63]} - {1'b0, r_dd};
    assign q_res = r_dnq ? (~r_dq + 64'd1) : r_dq;
    assign r_res = r_dnr ? (~r_dr + 64'd1) : r_dr;

    assign lc_word = r_q >> {r_acc[2:0], 3'b000};

    always_comb begin
        sc_word = r_q;
        sc_word[{r_bsel, 3'b000} +: 8] = r_acc[7:0];
    end

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_sp        = r_sp;
        n_bp        = r_bp;
        n_acc       = r_acc;
        n_count     = r_count;
        n_status    = r_status;
        n_rv        = r_rv;
        n_opc       = r_opc;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_widx      = r_widx;
        n_bsel      = r_bsel;
        n_ma        = r_ma;
        n_p0        = r_p0;
        n_p1        = r_p1;
        n_dq        = r_dq;
        n_dr        = r_dr;
        n_dd        = r_dd;
        n_dnq       = r_dnq;
        n_dnr       = r_dnr;
        mem_we      = 1'b0;
        mem_widx    = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_ridx    = f_idx({49'd0, r_pc});

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_rv    = '0;
                    n_state = S_DONE;
                    case (i_in_beat.mode)
                        MD_WRITE: begin
                            mem_we    = 1'b1;
                            mem_widx  = f_idx({49'd0, i_in_beat.address});
                            mem_wdata = i_in_beat.write_value;
                        end
                        MD_READ: begin
                            mem_re   = 1'b1;
                            mem_ridx = f_idx({49'd0, i_in_beat.address});
                            n_state  = S_RD;
                        end
                        MD_START: begin
                            n_sp     = SP_TOP;
                            n_bp     = SP_TOP;
                            n_pc     = r_entry;
                            n_count  = '0;
                            n_status = ST_RUN;
                            n_cnt    = '0;
                            n_state  = S_START;
                        end
                        MD_EXEC: begin
                            if (r_status == ST_RUN) begin
                                n_count = (r_count == '1) ? r_count : r_count + 32'd1;
                                mem_re  = 1'b1;
                                n_pc    = pc_p8;
                                n_state = S_OP;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_RD: begin
                n_rv    = r_q;
                n_state = S_DONE;
            end

            // exit trampoline: EXIT, PUSH, argc, argv, trampoline address
            S_START: begin
                mem_we   = 1'b1;
                mem_widx = f_idx({48'd0, sp_m8});
                case (r_cnt[2:0])
                    3'd0:    mem_wdata = {58'd0, OP_EXIT};
                    3'd1:    mem_wdata = {58'd0, OP_PUSH};
                    3'd2:    mem_wdata = {48'd0, r_argc};
                    3'd3:    mem_wdata = {49'd0, r_argv};
                    default: mem_wdata = {48'd0, TRAMP};
                endcase
                n_sp  = sp_m8;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd4) n_state = S_DONE;
            end

            // r_q holds the opcode word
            S_OP: begin
                n_opc   = opc;
                n_state = S_EX1;
                case (opc)
                    OP_IMM, OP_LEA, OP_NVAR, OP_DARG: begin
                        mem_re = 1'b1;
                        n_pc   = pc_p8;
                    end
                    OP_JMP, OP_JZ, OP_JNZ, OP_CALL: mem_re = 1'b1;
                    OP_RET: begin
                        n_sp     = r_bp;
                        mem_re   = 1'b1;
                        mem_ridx = f_idx({48'd0, r_bp});
                    end
                    OP_LI, OP_LC: begin
                        mem_re   = 1'b1;
                        mem_ridx = f_idx(r_acc);
                    end
                    OP_SI, OP_SC, OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT, OP_GT,
                    OP_LE, OP_GE, OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL: begin
                        mem_re   = 1'b1;
                        mem_ridx = f_idx({48'd0, r_sp});
                        n_sp     = sp_p8;
                    end
                    OP_DIV, OP_MOD: begin
                        if (r_acc == '0) begin
                            n_status = ST_DIV0;
                            n_state  = S_DONE;
                        end else begin
                            mem_re   = 1'b1;
                            mem_ridx = f_idx({48'd0, r_sp});
                            n_sp     = sp_p8;
                        end
                    end
                    OP_PUSH: begin
                        mem_we    = 1'b1;
                        mem_widx  = f_idx({48'd0, sp_m8});
                        mem_wdata = r_acc;
                        n_sp      = sp_m8;
                        n_state   = S_DONE;
                    end
                    OP_EXIT: begin
                        n_status = ST_EXIT;
                        mem_re   = 1'b1;
                        mem_ridx = f_idx({48'd0, r_sp});
                    end
                    default: begin
                        n_status = (opc inside {[OP_HOST_LO:OP_HOST_HI]}) ? ST_HOST : ST_BAD;
                        n_state  = S_DONE;
                    end
                endcase
            end

            // r_q holds the immediate, the popped word or the loaded word
            S_EX1: begin
                n_state = S_DONE;
                case (r_opc)
                    OP_IMM:  n_acc = r_q;
                    OP_LEA:  n_acc = {48'd0, r_bp} + {r_q[60:0], 3'b000};
                    OP_JMP:  n_pc = r_q[14:0];
                    OP_JZ:   n_pc = (r_acc != '0) ? pc_p8 : r_q[14:0];
                    OP_JNZ:  n_pc = (r_acc != '0) ? r_q[14:0] : pc_p8;
                    OP_CALL: begin
                        mem_we    = 1'b1;
                        mem_widx  = f_idx({48'd0, sp_m8});
                        mem_wdata = {49'd0, pc_p8};
                        n_sp      = sp_m8;
                        n_pc      = r_q[14:0];
                    end
                    OP_NVAR: begin
                        mem_we    = 1'b1;
                        mem_widx  = f_idx({48'd0, sp_m8});
                        mem_wdata = {48'd0, r_bp};
                        n_bp      = sp_m8;
                        n_sp      = sp_m8 - {r_q[12:0], 3'b000};
                    end
                    OP_DARG: n_sp = r_sp + {r_q[12:0], 3'b000};
                    OP_RET: begin
                        n_bp     = r_q[15:0];
                        mem_re   = 1'b1;
                        mem_ridx = f_idx({48'd0, sp_p8});
                        n_sp     = r_sp + 16'd16;
                        n_state  = S_EX2;
                    end
                    OP_LI:   n_acc = r_q;
                    OP_LC:   n_acc = f_sext8(lc_word[7:0]);
                    OP_SI: begin
                        mem_we    = 1'b1;
                        mem_widx  = f_idx(r_q);
                        mem_wdata = r_acc;
                    end
                    OP_SC: begin
                        n_widx   = f_idx(r_q);
                        n_bsel   = r_q[2:0];
                        mem_re   = 1'b1;
                        mem_ridx = f_idx(r_q);
                        n_state  = S_EX2;
                    end
                    OP_OR:   n_acc = r_q | r_acc;
                    OP_XOR:  n_acc = r_q ^ r_acc;
                    OP_AND:  n_acc = r_q & r_acc;
                    OP_EQ:   n_acc = {63'd0, r_q == r_acc};
                    OP_NE:   n_acc = {63'd0, r_q != r_acc};
                    OP_LT:   n_acc = {63'd0, $signed(r_q) < $signed(r_acc)};
                    OP_GT:   n_acc = {63'd0, $signed(r_acc) < $signed(r_q)};
                    OP_LE:   n_acc = {63'd0, !($signed(r_acc) < $signed(r_q))};
                    OP_GE:   n_acc = {63'd0, !($signed(r_q) < $signed(r_acc))};
                    OP_SHL:  n_acc = r_q << r_acc[5:0];
                    OP_SHR:  n_acc = $unsigned($signed(r_q) >>> r_acc[5:0]);
                    OP_ADD:  n_acc = r_q + r_acc;
                    OP_SUB:  n_acc = r_q - r_acc;
                    OP_MUL: begin
                        n_ma    = r_q;
                        n_cnt   = '0;
                        n_state = S_MUL;
                    end
                    OP_DIV, OP_MOD: begin
                        n_dq    = f_abs(r_q);
                        n_dd    = f_abs(r_acc);
                        n_dr    = '0;
                        n_dnq   = r_q[63] ^ r_acc[63];
                        n_dnr   = r_q[63];
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                    OP_EXIT: n_rv = r_q;
                    default: ;
                endcase
            end

            S_EX2: begin
                n_state = S_DONE;
                if (r_opc == OP_RET) begin
                    n_pc = r_q[14:0];
                end else begin
                    mem_we    = 1'b1;
                    mem_widx  = r_widx;
                    mem_wdata = sc_word;
                    n_acc     = f_sext8(r_acc[7:0]);
                end
            end

            S_MUL: begin
                n_cnt = r_cnt + 6'd1;
                case (r_cnt[1:0])
                    2'd0: n_p0 = mul_p;
                    2'd1: n_p1 = mul_p[31:0];
                    default: begin
                        n_p1    = r_p1 + mul_p[31:0];
                        n_state = S_MULF;
                    end
                endcase
            end

            S_MULF: begin
                n_acc   = r_p0 + {r_p1, 32'd0};
                n_state = S_DONE;
            end

            S_DIV: begin
                n_cnt = r_cnt + 6'd1;
                if (!div_t[64]) begin
                    n_dr = div_t[63:0];
                    n_dq = {r_dq[62:0], 1'b1};
                end else begin
                    n_dr = {r_dr[62:0], r_dq[63]};
                    n_dq = {r_dq[62:0], 1'b0};
                end
                if (r_cnt == 6'd63) n_state = S_DIVF;
            end

            S_DIVF: begin
                n_acc   = (r_opc == OP_DIV) ? q_res : r_res;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid               = 1'b1;
                    n_out.status              = r_status;
                    n_out.program_counter     = r_pc;
                    n_out.accumulator         = r_acc;
                    n_out.stack_pointer       = r_sp;
                    n_out.frame_pointer       = r_bp;
                    n_out.read_value          = r_rv;
                    n_out.instruction_count   = r_count;
                    n_state                   = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_sp        <= SP_TOP;
            r_bp        <= SP_TOP;
            r_acc       <= '0;
            r_count     <= '0;
            r_status    <= ST_RUN;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_sp        <= n_sp;
            r_bp        <= n_bp;
            r_acc       <= n_acc;
            r_count     <= n_count;
            r_status    <= n_status;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rv   <= n_rv;
        r_opc  <= n_opc;
        r_out  <= n_out;
        r_widx <= n_widx;
        r_bsel <= n_bsel;
        r_ma   <= n_ma;
        r_p0   <= n_p0;
        r_p1   <= n_p1;
        r_dq   <= n_dq;
        r_dr   <= n_dr;
        r_dd   <= n_dd;
        r_dnq  <= n_dnq;
        r_dnr  <= n_dnr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_widx] <= mem_wdata;
        if (mem_re) r_q <= mem[mem_ridx];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // accesses are sequenced so read and write never share a cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("memory read and write in the same cycle");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_beat.mode == MD_START |=> r_status == ST_RUN && r_count == '0)
        else $error("start did not clear status and count");

    a_halted_holds_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_beat.mode == MD_EXEC && r_status != ST_RUN
        |=> $stable(r_pc) && $stable(r_sp) && r_state == S_DONE)
        else $error("halted machine changed state");

endmodule
